>>> rtl/gbhe_pkg.sv
package gbhe_pkg;

    // Field widths
    localparam int unsigned ByteW   = 8;
    localparam int unsigned CountW  = 7;
    localparam int unsigned TickW   = 16;
    localparam int unsigned WaitW   = 17;
    localparam int unsigned ModeW   = 2;
    localparam int unsigned CmdW    = 2;
    localparam int unsigned StatusW = 3;
    localparam int unsigned CfgIdxW = 2;
    localparam int unsigned CfgW    = 16;

    // Command codes
    localparam logic [CmdW-1:0] CMD_TICK = 2'd0;
    localparam logic [CmdW-1:0] CMD_RECV = 2'd1;
    localparam logic [CmdW-1:0] CMD_SEND = 2'd2;

    // Receive modes (3 behaves as length only)
    localparam logic [ModeW-1:0] MODE_LENGTH = 2'd0;
    localparam logic [ModeW-1:0] MODE_EOI    = 2'd1;
    localparam logic [ModeW-1:0] MODE_LF     = 2'd2;

    // Status codes
    localparam logic [StatusW-1:0] ST_NONE    = 3'd0;
    localparam logic [StatusW-1:0] ST_OK      = 3'd1;
    localparam logic [StatusW-1:0] ST_TIMEOUT = 3'd2;
    localparam logic [StatusW-1:0] ST_NO_LSTN = 3'd3;
    localparam logic [StatusW-1:0] ST_REFUSED = 3'd4;

    // Register indexes
    localparam logic [CfgIdxW-1:0] REG_TIMEOUT = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_MODE    = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_MAX_RX  = 2'd2;
    localparam logic [CfgIdxW-1:0] REG_SETTLE  = 2'd3;

    // Register reset values
    localparam logic [TickW-1:0]  TIMEOUT_RST = 16'd50000;
    localparam logic [ModeW-1:0]  MODE_RST    = MODE_EOI;
    localparam logic [CountW-1:0] MAX_RX_RST  = 7'd126;
    localparam logic [TickW-1:0]  SETTLE_RST  = 16'd100;

    localparam logic [ByteW-1:0] LF_CODE = 8'h0A;

    typedef enum logic [6:0] {
        PH_IDLE    = 7'b0000001,
        PH_RX_LOW  = 7'b0000010,
        PH_RX_HIGH = 7'b0000100,
        PH_TX_SET1 = 7'b0001000,
        PH_TX_NRFD = 7'b0010000,
        PH_TX_SET2 = 7'b0100000,
        PH_TX_NDAC = 7'b1000000
    } phase_t;

    // Levels driven onto the bus; 0 pulls a line low
    typedef struct packed {
        logic             atn;
        logic             ndac;
        logic             nrfd;
        logic             eoi;
        logic             dav;
        logic [ByteW-1:0] data;
    } lines_t;

    localparam lines_t LINES_RST = '{atn: 1'b1, ndac: 1'b1, nrfd: 1'b1, eoi: 1'b1,
                                     dav: 1'b1, data: '0};

    typedef struct packed {
        logic [TickW-1:0]  timeout_limit;
        logic [ModeW-1:0]  receive_mode;
        logic [CountW-1:0] max_receive;
        logic [TickW-1:0]  settle_ticks;
    } cfg_t;

    typedef struct packed {
        logic [CmdW-1:0]  command;
        logic [ByteW-1:0] tx_byte;
        logic             last_byte;
        logic             send_end;
        logic             as_command;
        logic             dav_level;
        logic             nrfd_level;
        logic             ndac_level;
        logic             eoi_level;
        logic [ByteW-1:0] bus_data;
    } beat_in_t;

    typedef struct packed {
        lines_t              lines;
        logic [ByteW-1:0]    rx_byte;
        logic                rx_valid;
        logic                done_res;
        logic [StatusW-1:0]  status;
        logic [CountW-1:0]   byte_count;
    } beat_out_t;

endpackage

>>> rtl/gbhe_fsm.sv
// Handshake sequencer: state registers plus the per-tick next-state logic.
module gbhe_fsm (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step,
    input  gbhe_pkg::cfg_t       cfg,
    input  gbhe_pkg::beat_in_t   beat,
    output gbhe_pkg::beat_out_t  result
);

    gbhe_pkg::phase_t                 phase_reg, phase_next;
    logic [gbhe_pkg::WaitW-1:0]       wait_reg, wait_next, wait_inc;
    logic [gbhe_pkg::TickW-1:0]       settle_reg, settle_next;
    logic [gbhe_pkg::CountW-1:0]      count_reg, count_next;
    logic                             stop_reg, stop_next;
    logic                             last_reg, last_next;
    logic                             msg_reg, msg_next;
    gbhe_pkg::lines_t                 lines_reg, lines_next;

    logic                             expired;
    logic                             refused;
    logic                             done;
    logic [gbhe_pkg::StatusW-1:0]     st;
    logic                             rxv;
    logic [gbhe_pkg::ByteW-1:0]       rxb;
    logic [gbhe_pkg::ByteW-1:0]       bus_byte;

    assign wait_inc = wait_reg + 1'b1;
    assign expired  = wait_inc > {1'b0, cfg.timeout_limit};
    assign bus_byte = ~beat.bus_data;

    always_comb begin
        phase_next  = phase_reg;
        wait_next   = wait_reg;
        settle_next = settle_reg;
        count_next  = count_reg;
        stop_next   = stop_reg;
        last_next   = last_reg;
        msg_next    = msg_reg;
        lines_next  = lines_reg;
        done        = 1'b0;
        st          = gbhe_pkg::ST_NONE;
        rxv         = 1'b0;
        rxb         = '0;
        refused     = (phase_reg != gbhe_pkg::PH_IDLE) &&
                      (beat.command == gbhe_pkg::CMD_RECV ||
                       beat.command == gbhe_pkg::CMD_SEND);

        case (phase_reg)
            gbhe_pkg::PH_IDLE: begin
                if (beat.command == gbhe_pkg::CMD_RECV) begin
                    if (msg_reg) begin
                        refused = 1'b1;
                    end else begin
                        count_next      = '0;
                        wait_next       = '0;
                        stop_next       = 1'b0;
                        lines_next.nrfd = 1'b1;
                        lines_next.ndac = 1'b0;
                        phase_next      = gbhe_pkg::PH_RX_LOW;
                    end
                end else if (beat.command == gbhe_pkg::CMD_SEND) begin
                    if (!msg_reg && beat.nrfd_level && beat.ndac_level) begin
                        done = 1'b1;
                        st   = gbhe_pkg::ST_NO_LSTN;
                    end else begin
                        last_next       = beat.last_byte;
                        lines_next.data = ~beat.tx_byte;
                        lines_next.eoi  = ~(beat.last_byte & beat.send_end);
                        if (!msg_reg) begin
                            lines_next.atn = ~beat.as_command;
                        end
                        msg_next    = 1'b1;
                        settle_next = '0;
                        wait_next   = '0;
                        phase_next  = gbhe_pkg::PH_TX_SET1;
                    end
                end
            end
            gbhe_pkg::PH_RX_LOW: begin
                if (beat.dav_level) begin
                    wait_next = wait_inc;
                    if (expired) begin
                        lines_next = gbhe_pkg::LINES_RST;
                        phase_next = gbhe_pkg::PH_IDLE;
                        msg_next   = 1'b0;
                        done       = 1'b1;
                        st         = gbhe_pkg::ST_TIMEOUT;
                    end
                end else begin
                    rxv        = 1'b1;
                    rxb        = bus_byte;
                    count_next = count_reg + 1'b1;
                    stop_next  = (count_next >= cfg.max_receive) ||
                                 (cfg.receive_mode == gbhe_pkg::MODE_EOI && !beat.eoi_level) ||
                                 (cfg.receive_mode == gbhe_pkg::MODE_LF &&
                                  bus_byte == gbhe_pkg::LF_CODE);
                    lines_next.nrfd = 1'b0;
                    lines_next.ndac = 1'b1;
                    phase_next      = gbhe_pkg::PH_RX_HIGH;
                end
            end
            gbhe_pkg::PH_RX_HIGH: begin
                if (!beat.dav_level) begin
                    wait_next = wait_inc;
                    if (expired) begin
                        lines_next = gbhe_pkg::LINES_RST;
                        phase_next = gbhe_pkg::PH_IDLE;
                        msg_next   = 1'b0;
                        done       = 1'b1;
                        st         = gbhe_pkg::ST_TIMEOUT;
                    end
                end else if (stop_reg) begin
                    lines_next = gbhe_pkg::LINES_RST;
                    phase_next = gbhe_pkg::PH_IDLE;
                    msg_next   = 1'b0;
                    done       = 1'b1;
                    st         = gbhe_pkg::ST_OK;
                end else begin
                    lines_next.ndac = 1'b0;
                    lines_next.nrfd = 1'b1;
                    wait_next       = '0;
                    phase_next      = gbhe_pkg::PH_RX_LOW;
                end
            end
            gbhe_pkg::PH_TX_SET1, gbhe_pkg::PH_TX_SET2: begin
                if (settle_reg < cfg.settle_ticks) begin
                    settle_next = settle_reg + 1'b1;
                end else if (phase_reg == gbhe_pkg::PH_TX_SET1) begin
                    phase_next = gbhe_pkg::PH_TX_NRFD;
                end else begin
                    phase_next = gbhe_pkg::PH_TX_NDAC;
                end
            end
            gbhe_pkg::PH_TX_NRFD: begin
                if (beat.nrfd_level) begin
                    lines_next.dav = 1'b0;
                    settle_next    = '0;
                    phase_next     = gbhe_pkg::PH_TX_SET2;
                end else begin
                    wait_next = wait_inc;
                    if (expired) begin
                        lines_next = gbhe_pkg::LINES_RST;
                        phase_next = gbhe_pkg::PH_IDLE;
                        msg_next   = 1'b0;
                        done       = 1'b1;
                        st         = gbhe_pkg::ST_TIMEOUT;
                    end
                end
            end
            gbhe_pkg::PH_TX_NDAC: begin
                if (beat.ndac_level) begin
                    lines_next.dav = 1'b1;
                    lines_next.eoi = 1'b1;
                    done           = 1'b1;
                    st             = gbhe_pkg::ST_OK;
                    phase_next     = gbhe_pkg::PH_IDLE;
                    if (last_reg) begin
                        lines_next = gbhe_pkg::LINES_RST;
                        msg_next   = 1'b0;
                    end
                end else begin
                    wait_next = wait_inc;
                    if (expired) begin
                        lines_next = gbhe_pkg::LINES_RST;
                        phase_next = gbhe_pkg::PH_IDLE;
                        msg_next   = 1'b0;
                        done       = 1'b1;
                        st         = gbhe_pkg::ST_TIMEOUT;
                    end
                end
            end
            default: begin
                lines_next = gbhe_pkg::LINES_RST;
                phase_next = gbhe_pkg::PH_IDLE;
                msg_next   = 1'b0;
            end
        endcase

        if (refused && !done) begin
            st = gbhe_pkg::ST_REFUSED;
        end
    end

    assign result.lines      = lines_next;
    assign result.rx_byte    = rxb;
    assign result.rx_valid   = rxv;
    assign result.done_res   = done;
    assign result.status     = st;
    assign result.byte_count = count_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= gbhe_pkg::PH_IDLE;
            wait_reg   <= '0;
            settle_reg <= '0;
            count_reg  <= '0;
            stop_reg   <= 1'b0;
            last_reg   <= 1'b0;
            msg_reg    <= 1'b0;
            lines_reg  <= gbhe_pkg::LINES_RST;
        end else if (step) begin
            phase_reg  <= phase_next;
            wait_reg   <= wait_next;
            settle_reg <= settle_next;
            count_reg  <= count_next;
            stop_reg   <= stop_next;
            last_reg   <= last_next;
            msg_reg    <= msg_next;
            lines_reg  <= lines_next;
        end
    end

endmodule

>>> rtl/gpib_byte_handshake_engine.sv
// IEEE 488 three-wire handshake engine, acceptor and source.
// Input channel (s_*): one beat per bus sample. Each beat carries a command
//   (tick only, start receive, send one byte), the byte to send with its
//   last/EOI/ATN flags, and the sampled DAV, NRFD, NDAC, EOI and data lines.
// Result channel (m_*): exactly one beat per input beat, carrying the line
//   levels to drive after that tick, any received byte, a done flag, a status
//   code and the running receive count.
// Config channel (cfg_*): writes timeout, receive mode, max length and settle
//   time by register index; always ready, meant to be used while idle.
// Timing: the result beat is registered and appears on the m_ side in the cycle
//   after its input beat is taken. Throughput: one beat per cycle while m_ready is
//   high, set by the single result register, which is refilled in the same cycle it drains.
// Stall: s_ready drops only while a result sits in the output register and
//   m_ready is low; nothing is lost or repeated.
// Reset (aresetn low, synchronous): sequencer idle, all control lines
//   released high, data lines zero, config registers back to defaults.
module gpib_byte_handshake_engine (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [gbhe_pkg::CmdW-1:0]         s_command,
    input  logic [gbhe_pkg::ByteW-1:0]        s_tx_byte,
    input  logic                              s_last_byte,
    input  logic                              s_send_end,
    input  logic                              s_as_command,
    input  logic                              s_dav_level,
    input  logic                              s_nrfd_level,
    input  logic                              s_ndac_level,
    input  logic                              s_eoi_level,
    input  logic [gbhe_pkg::ByteW-1:0]        s_bus_data,

    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [gbhe_pkg::ByteW-1:0]        m_data_out,
    output logic                              m_dav_drive,
    output logic                              m_eoi_drive,
    output logic                              m_nrfd_drive,
    output logic                              m_ndac_drive,
    output logic                              m_atn_drive,
    output logic [gbhe_pkg::ByteW-1:0]        m_rx_byte,
    output logic                              m_rx_valid,
    output logic                              m_done_res,
    output logic [gbhe_pkg::StatusW-1:0]      m_status,
    output logic [gbhe_pkg::CountW-1:0]       m_byte_count,

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [gbhe_pkg::CfgIdxW-1:0]      cfg_index,
    input  logic [gbhe_pkg::CfgW-1:0]         cfg_data
);

    gbhe_pkg::cfg_t      cfg_reg;
    gbhe_pkg::beat_in_t  beat;
    gbhe_pkg::beat_out_t result;
    gbhe_pkg::beat_out_t out_reg;
    logic                out_valid_reg;
    logic                step;

    // Output slot is free when empty or being drained this cycle
    assign s_ready   = !out_valid_reg || m_ready;
    assign step      = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.timeout_limit <= gbhe_pkg::TIMEOUT_RST;
            cfg_reg.receive_mode  <= gbhe_pkg::MODE_RST;
            cfg_reg.max_receive   <= gbhe_pkg::MAX_RX_RST;
            cfg_reg.settle_ticks  <= gbhe_pkg::SETTLE_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                gbhe_pkg::REG_TIMEOUT: begin
                    cfg_reg.timeout_limit <= cfg_data;
                end
                gbhe_pkg::REG_MODE: begin
                    cfg_reg.receive_mode <= cfg_data[gbhe_pkg::ModeW-1:0];
                end
                gbhe_pkg::REG_MAX_RX: begin
                    cfg_reg.max_receive <= cfg_data[gbhe_pkg::CountW-1:0];
                end
                gbhe_pkg::REG_SETTLE: begin
                    cfg_reg.settle_ticks <= cfg_data;
                end
                default: begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    assign beat.command    = s_command;
    assign beat.tx_byte    = s_tx_byte;
    assign beat.last_byte  = s_last_byte;
    assign beat.send_end   = s_send_end;
    assign beat.as_command = s_as_command;
    assign beat.dav_level  = s_dav_level;
    assign beat.nrfd_level = s_nrfd_level;
    assign beat.ndac_level = s_ndac_level;
    assign beat.eoi_level  = s_eoi_level;
    assign beat.bus_data   = s_bus_data;

    gbhe_fsm u_fsm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .cfg     (cfg_reg),
        .beat    (beat),
        .result  (result)
    );

    // Result register; payload needs no reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_reg <= result;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_data_out   = out_reg.lines.data;
    assign m_dav_drive  = out_reg.lines.dav;
    assign m_eoi_drive  = out_reg.lines.eoi;
    assign m_nrfd_drive = out_reg.lines.nrfd;
    assign m_ndac_drive = out_reg.lines.ndac;
    assign m_atn_drive  = out_reg.lines.atn;
    assign m_rx_byte    = out_reg.rx_byte;
    assign m_rx_valid   = out_reg.rx_valid;
    assign m_done_res   = out_reg.done_res;
    assign m_status     = out_reg.status;
    assign m_byte_count = out_reg.byte_count;

endmodule

>>> bench/tb_gpib_byte_handshake_engine.sv
module tb_gpib_byte_handshake_engine;
    timeunit 1ns;
    timeprecision 1ps;

    // Selector values with no meaning of their own
    localparam logic [gbhe_pkg::CmdW-1:0]  CMD_SPARE  = 2'd3;  // decodes as tick only
    localparam logic [gbhe_pkg::ModeW-1:0] MODE_SPARE = 2'd3;  // decodes as length only

    // ------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------
    logic                               aclk;
    logic                               aresetn   = 1'b0;
    logic                               s_valid   = 1'b0;
    logic                               s_ready;
    gbhe_pkg::beat_in_t                 s_beat    = '0;
    logic                               m_valid;
    logic                               m_ready   = 1'b0;
    logic [gbhe_pkg::ByteW-1:0]         m_data_out;
    logic                               m_dav_drive;
    logic                               m_eoi_drive;
    logic                               m_nrfd_drive;
    logic                               m_ndac_drive;
    logic                               m_atn_drive;
    logic [gbhe_pkg::ByteW-1:0]         m_rx_byte;
    logic                               m_rx_valid;
    logic                               m_done_res;
    logic [gbhe_pkg::StatusW-1:0]       m_status;
    logic [gbhe_pkg::CountW-1:0]        m_byte_count;
    logic                               cfg_valid = 1'b0;
    logic                               cfg_ready;
    logic [gbhe_pkg::CfgIdxW-1:0]       cfg_index = gbhe_pkg::REG_TIMEOUT;
    logic [gbhe_pkg::CfgW-1:0]          cfg_data  = '0;

    // ------------------------------------------------------------------
    // Handshake predictor state: mirrors the engine's sequencer, counters,
    // held byte and line levels, plus its copy of the register file.
    // ------------------------------------------------------------------
    gbhe_pkg::cfg_t     hs_cfg = '{timeout_limit: gbhe_pkg::TIMEOUT_RST,
                                   receive_mode: gbhe_pkg::MODE_RST,
                                   max_receive: gbhe_pkg::MAX_RX_RST,
                                   settle_ticks: gbhe_pkg::SETTLE_RST};
    gbhe_pkg::phase_t               hs_phase     = gbhe_pkg::PH_IDLE;
    logic [gbhe_pkg::WaitW-1:0]     wait_cnt     = '0;
    logic [gbhe_pkg::TickW-1:0]     settle_cnt   = '0;
    logic [gbhe_pkg::CountW-1:0]    rx_cnt       = '0;
    logic                           stop_pending = 1'b0;
    logic [gbhe_pkg::ByteW-1:0]     held_byte    = '0;
    logic                           held_last    = 1'b0;
    logic                           msg_open     = 1'b0;
    gbhe_pkg::lines_t               hs_lines     = gbhe_pkg::LINES_RST;

    gbhe_pkg::beat_out_t pending_reports[$];   // expected result beats, oldest first
    int unsigned         send_idle_pct = 0;    // chance the sender idles instead of presenting a beat
    int unsigned         stall_pct     = 0;    // chance the receiver drops m_ready
    int unsigned         mismatches    = 0;

    gpib_byte_handshake_engine dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_command    (s_beat.command),
        .s_tx_byte    (s_beat.tx_byte),
        .s_last_byte  (s_beat.last_byte),
        .s_send_end   (s_beat.send_end),
        .s_as_command (s_beat.as_command),
        .s_dav_level  (s_beat.dav_level),
        .s_nrfd_level (s_beat.nrfd_level),
        .s_ndac_level (s_beat.ndac_level),
        .s_eoi_level  (s_beat.eoi_level),
        .s_bus_data   (s_beat.bus_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data_out   (m_data_out),
        .m_dav_drive  (m_dav_drive),
        .m_eoi_drive  (m_eoi_drive),
        .m_nrfd_drive (m_nrfd_drive),
        .m_ndac_drive (m_ndac_drive),
        .m_atn_drive  (m_atn_drive),
        .m_rx_byte    (m_rx_byte),
        .m_rx_valid   (m_rx_valid),
        .m_done_res   (m_done_res),
        .m_status     (m_status),
        .m_byte_count (m_byte_count),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Hard stop, many times the length of a full run even with the longest stalls
    initial begin
        #200us;
        $display("end of test: mismatches");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Shared wait counter; a wait gives up once the count passes the limit.
    function automatic logic wait_expired();
        wait_cnt = wait_cnt + 1'b1;
        return wait_cnt > {1'b0, hs_cfg.timeout_limit};
    endfunction

    // End of message: lines back to released levels, send message closed.
    function automatic void release_bus();
        hs_lines = gbhe_pkg::LINES_RST;
        hs_phase = gbhe_pkg::PH_IDLE;
        msg_open = 1'b0;
    endfunction

    function automatic gbhe_pkg::beat_out_t advance_handshake(input gbhe_pkg::beat_in_t b);
        gbhe_pkg::beat_out_t r;
        logic                refused;
        r = '0;
        refused = (hs_phase != gbhe_pkg::PH_IDLE) &&
                  (b.command == gbhe_pkg::CMD_RECV || b.command == gbhe_pkg::CMD_SEND);
        case (hs_phase)
            gbhe_pkg::PH_IDLE: begin
                if (b.command == gbhe_pkg::CMD_RECV) begin
                    if (msg_open) begin
                        refused = 1'b1;     // cannot listen mid send message
                    end else begin
                        rx_cnt       = '0;
                        wait_cnt     = '0;
                        stop_pending = 1'b0;
                        hs_lines.nrfd = 1'b1;
                        hs_lines.ndac = 1'b0;
                        hs_phase     = gbhe_pkg::PH_RX_LOW;
                    end
                end else if (b.command == gbhe_pkg::CMD_SEND) begin
                    if (!msg_open && b.nrfd_level && b.ndac_level) begin
                        // nobody pulls either line: no listener, nothing moves
                        r.done_res = 1'b1;
                        r.status   = gbhe_pkg::ST_NO_LSTN;
                    end else begin
                        held_byte     = b.tx_byte;
                        held_last     = b.last_byte;
                        hs_lines.data = ~b.tx_byte;
                        hs_lines.eoi  = ~(b.last_byte & b.send_end);
                        if (!msg_open) hs_lines.atn = ~b.as_command;
                        msg_open   = 1'b1;
                        settle_cnt = '0;
                        wait_cnt   = '0;
                        hs_phase   = gbhe_pkg::PH_TX_SET1;
                    end
                end
            end
            gbhe_pkg::PH_RX_LOW: begin
                if (b.dav_level) begin
                    if (wait_expired()) begin
                        release_bus();
                        r.done_res = 1'b1;
                        r.status   = gbhe_pkg::ST_TIMEOUT;
                    end
                end else begin
                    held_byte  = ~b.bus_data;
                    rx_cnt     = rx_cnt + 1'b1;
                    r.rx_valid = 1'b1;
                    r.rx_byte  = held_byte;
                    stop_pending = (rx_cnt >= hs_cfg.max_receive)
                        || (hs_cfg.receive_mode == gbhe_pkg::MODE_EOI && !b.eoi_level)
                        || (hs_cfg.receive_mode == gbhe_pkg::MODE_LF &&
                            held_byte == gbhe_pkg::LF_CODE);
                    hs_lines.nrfd = 1'b0;
                    hs_lines.ndac = 1'b1;
                    hs_phase      = gbhe_pkg::PH_RX_HIGH;
                end
            end
            gbhe_pkg::PH_RX_HIGH: begin
                if (!b.dav_level) begin
                    if (wait_expired()) begin
                        release_bus();
                        r.done_res = 1'b1;
                        r.status   = gbhe_pkg::ST_TIMEOUT;
                    end
                end else if (stop_pending) begin
                    release_bus();
                    r.done_res = 1'b1;
                    r.status   = gbhe_pkg::ST_OK;
                end else begin
                    hs_lines.ndac = 1'b0;
                    hs_lines.nrfd = 1'b1;
                    wait_cnt      = '0;
                    hs_phase      = gbhe_pkg::PH_RX_LOW;
                end
            end
            gbhe_pkg::PH_TX_SET1, gbhe_pkg::PH_TX_SET2: begin
                if (settle_cnt < hs_cfg.settle_ticks) settle_cnt = settle_cnt + 1'b1;
                else hs_phase = (hs_phase == gbhe_pkg::PH_TX_SET1) ? gbhe_pkg::PH_TX_NRFD
                                                                   : gbhe_pkg::PH_TX_NDAC;
            end
            gbhe_pkg::PH_TX_NRFD: begin
                if (b.nrfd_level) begin
                    hs_lines.dav = 1'b0;
                    settle_cnt   = '0;
                    hs_phase     = gbhe_pkg::PH_TX_SET2;
                end else if (wait_expired()) begin
                    release_bus();
                    r.done_res = 1'b1;
                    r.status   = gbhe_pkg::ST_TIMEOUT;
                end
            end
            gbhe_pkg::PH_TX_NDAC: begin
                if (b.ndac_level) begin
                    hs_lines.dav = 1'b1;
                    hs_lines.eoi = 1'b1;
                    r.done_res   = 1'b1;
                    r.status     = gbhe_pkg::ST_OK;
                    if (held_last) release_bus();
                    else hs_phase = gbhe_pkg::PH_IDLE;
                end else if (wait_expired()) begin
                    release_bus();
                    r.done_res = 1'b1;
                    r.status   = gbhe_pkg::ST_TIMEOUT;
                end
            end
            default: release_bus();
        endcase
        // a byte or transfer ending on this tick outranks the refusal
        if (refused && !r.done_res) r.status = gbhe_pkg::ST_REFUSED;
        r.lines      = hs_lines;
        r.byte_count = rx_cnt;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Beat builders
    // ------------------------------------------------------------------

    // Quiet bus: DAV and EOI released, listeners holding NRFD/NDAC low.
    function automatic gbhe_pkg::beat_in_t bus_idle();
        gbhe_pkg::beat_in_t b;
        b = '0;
        b.command   = gbhe_pkg::CMD_TICK;
        b.dav_level = 1'b1;
        b.eoi_level = 1'b1;
        b.bus_data  = '1;
        return b;
    endfunction

    function automatic gbhe_pkg::beat_in_t cmd_beat(input logic [gbhe_pkg::CmdW-1:0] cmd);
        gbhe_pkg::beat_in_t b;
        b = bus_idle();
        b.command = cmd;
        return b;
    endfunction

    // Remote talker: DAV and EOI levels plus a byte placed on the lines.
    function automatic gbhe_pkg::beat_in_t talker(input logic dav, input logic eoi,
                                                  input logic [gbhe_pkg::ByteW-1:0] value);
        gbhe_pkg::beat_in_t b;
        b = bus_idle();
        b.dav_level = dav;
        b.eoi_level = eoi;
        b.bus_data  = ~value;
        return b;
    endfunction

    // Remote listeners: NRFD and NDAC levels.
    function automatic gbhe_pkg::beat_in_t listener(input logic nrfd, input logic ndac);
        gbhe_pkg::beat_in_t b;
        b = bus_idle();
        b.nrfd_level = nrfd;
        b.ndac_level = ndac;
        return b;
    endfunction

    function automatic gbhe_pkg::beat_in_t source_beat(
        input logic [gbhe_pkg::ByteW-1:0] value, input logic last,
        input logic send_end, input logic as_cmd,
        input logic nrfd, input logic ndac);
        gbhe_pkg::beat_in_t b;
        b = listener(nrfd, ndac);
        b.command    = gbhe_pkg::CMD_SEND;
        b.tx_byte    = value;
        b.last_byte  = last;
        b.send_end   = send_end;
        b.as_command = as_cmd;
        return b;
    endfunction

    // Random bus sample, steered by the predicted phase so that most beats
    // move the handshake forward; the rest is noise and refused commands.
    function automatic gbhe_pkg::beat_in_t random_beat();
        gbhe_pkg::beat_in_t b;
        int unsigned        pick;
        b.command    = gbhe_pkg::CmdW'($urandom_range(3));
        b.tx_byte    = gbhe_pkg::ByteW'($urandom_range(255));
        b.last_byte  = ($urandom_range(99) < 35);
        b.send_end   = 1'($urandom_range(1));
        b.as_command = 1'($urandom_range(1));
        b.dav_level  = 1'($urandom_range(1));
        b.nrfd_level = 1'($urandom_range(1));
        b.ndac_level = 1'($urandom_range(1));
        b.eoi_level  = 1'($urandom_range(1));
        b.bus_data   = gbhe_pkg::ByteW'($urandom_range(255));
        pick = $urandom_range(99);
        if (hs_phase == gbhe_pkg::PH_IDLE) begin
            if (msg_open) begin
                if (pick < 75) b.command = gbhe_pkg::CMD_SEND;
                else if (pick < 85) b.command = gbhe_pkg::CMD_RECV;
            end else begin
                if (pick < 45) b.command = gbhe_pkg::CMD_SEND;
                else if (pick < 85) b.command = gbhe_pkg::CMD_RECV;
            end
            // keep "no listener" a minority outcome
            if (b.nrfd_level && b.ndac_level && $urandom_range(4) != 0) b.ndac_level = 1'b0;
        end else if (pick < 88) begin
            b.command = gbhe_pkg::CMD_TICK;
        end
        case (hs_phase)
            gbhe_pkg::PH_RX_LOW: begin
                b.dav_level = ($urandom_range(99) >= 45);
                b.eoi_level = ($urandom_range(3) != 0);
                if ($urandom_range(5) == 0) b.bus_data = ~gbhe_pkg::LF_CODE;
            end
            gbhe_pkg::PH_RX_HIGH: b.dav_level  = ($urandom_range(99) < 65);
            gbhe_pkg::PH_TX_NRFD: b.nrfd_level = ($urandom_range(99) < 55);
            gbhe_pkg::PH_TX_NDAC: b.ndac_level = ($urandom_range(99) < 55);
            default: ;
        endcase
        return b;
    endfunction

    // ------------------------------------------------------------------
    // Driver
    // ------------------------------------------------------------------

    // Present one beat, optionally after random hold-off, and predict its
    // result once the beat is taken.
    task automatic send_beat(input gbhe_pkg::beat_in_t b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_beat  <= b;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        pending_reports.push_back(advance_handshake(b));
    endtask

    task automatic respond_until_idle(input gbhe_pkg::beat_in_t b);
        do send_beat(b); while (hs_phase != gbhe_pkg::PH_IDLE);
    endtask

    task automatic receive_byte(input logic [gbhe_pkg::ByteW-1:0] value, input logic eoi);
        send_beat(talker(1'b0, eoi, value));
        send_beat(talker(1'b1, 1'b1, value));
    endtask

    // Bring the engine back to idle with no send message open: an open
    // message is closed by a last byte that nobody takes (times out).
    task automatic settle_bus();
        gbhe_pkg::beat_in_t b;
        while (hs_phase != gbhe_pkg::PH_IDLE || msg_open) begin
            b = bus_idle();
            if (hs_phase == gbhe_pkg::PH_IDLE) begin
                b.command   = gbhe_pkg::CMD_SEND;
                b.last_byte = 1'b1;
            end
            send_beat(b);
        end
        s_valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [gbhe_pkg::CfgIdxW-1:0] idx,
                             input logic [gbhe_pkg::CfgW-1:0] value);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            gbhe_pkg::REG_TIMEOUT: hs_cfg.timeout_limit = value[gbhe_pkg::TickW-1:0];
            gbhe_pkg::REG_MODE:    hs_cfg.receive_mode  = value[gbhe_pkg::ModeW-1:0];
            gbhe_pkg::REG_MAX_RX:  hs_cfg.max_receive   = value[gbhe_pkg::CountW-1:0];
            gbhe_pkg::REG_SETTLE:  hs_cfg.settle_ticks  = value[gbhe_pkg::TickW-1:0];
            default: ;
        endcase
    endtask

    // Registers change only with the engine idle and every result in.
    task automatic configure(input logic [gbhe_pkg::TickW-1:0] tmo,
                             input logic [gbhe_pkg::ModeW-1:0] mode,
                             input logic [gbhe_pkg::CountW-1:0] max_rx,
                             input logic [gbhe_pkg::TickW-1:0] settle);
        settle_bus();
        write_reg(gbhe_pkg::REG_TIMEOUT, tmo);
        write_reg(gbhe_pkg::REG_MODE, gbhe_pkg::CfgW'(mode));
        write_reg(gbhe_pkg::REG_MAX_RX, gbhe_pkg::CfgW'(max_rx));
        write_reg(gbhe_pkg::REG_SETTLE, settle);
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Result checking; m_ready is rerolled every cycle
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin : report_check
        gbhe_pkg::beat_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_reports.size() == 0) begin
                $error("result beat with no expected report");
                mismatches++;
            end else begin
                want = pending_reports.pop_front();
                check_field("data_out",   want.lines.data, m_data_out);
                check_field("dav_drive",  want.lines.dav,  m_dav_drive);
                check_field("eoi_drive",  want.lines.eoi,  m_eoi_drive);
                check_field("nrfd_drive", want.lines.nrfd, m_nrfd_drive);
                check_field("ndac_drive", want.lines.ndac, m_ndac_drive);
                check_field("atn_drive",  want.lines.atn,  m_atn_drive);
                check_field("rx_byte",    want.rx_byte,    m_rx_byte);
                check_field("rx_valid",   want.rx_valid,   m_rx_valid);
                check_field("done_res",   want.done_res,   m_done_res);
                check_field("status",     want.status,     m_status);
                check_field("byte_count", want.byte_count, m_byte_count);
            end
        end
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset register values: EOI ends the message; refusals while listening.
    task automatic test_reset_defaults();
        gbhe_pkg::beat_in_t b;
        send_beat(cmd_beat(gbhe_pkg::CMD_TICK));
        send_beat(cmd_beat(CMD_SPARE));
        send_beat(cmd_beat(gbhe_pkg::CMD_RECV));
        send_beat(talker(1'b0, 1'b1, 8'h00));      // byte 00, EOI released
        send_beat(talker(1'b0, 1'b1, 8'h00));      // DAV still low: waiting for release
        b = talker(1'b1, 1'b1, 8'h00);
        b.command = gbhe_pkg::CMD_RECV;            // refused, acceptor rearms
        send_beat(b);
        b = talker(1'b0, 1'b0, 8'hFF);
        b.command = gbhe_pkg::CMD_SEND;            // refused, byte FF with EOI
        send_beat(b);
        send_beat(talker(1'b1, 1'b1, 8'hFF));      // message ends ok
    endtask

    // LF stop, length stop, spare mode with a zero max_receive.
    task automatic test_receive_modes();
        configure(16'd10, gbhe_pkg::MODE_LF, 7'd127, gbhe_pkg::SETTLE_RST);
        send_beat(cmd_beat(gbhe_pkg::CMD_RECV));
        receive_byte(8'h41, 1'b0);                 // EOI means nothing in LF mode
        receive_byte(gbhe_pkg::LF_CODE, 1'b1);

        configure(16'd10, gbhe_pkg::MODE_LENGTH, 7'd2, gbhe_pkg::SETTLE_RST);
        send_beat(cmd_beat(gbhe_pkg::CMD_RECV));
        receive_byte(gbhe_pkg::LF_CODE, 1'b0);
        receive_byte(8'h80, 1'b1);

        // spare mode acts as length only; a zero limit stops after one byte
        configure(16'd10, MODE_SPARE, 7'd0, gbhe_pkg::SETTLE_RST);
        send_beat(cmd_beat(gbhe_pkg::CMD_RECV));
        receive_byte(8'h7F, 1'b1);
    endtask

    // Source side: no listener, a two-byte command message with EOI on the
    // last byte, refusals while a byte or message is in progress, then a data message without EOI.
    task automatic test_send_path();
        gbhe_pkg::beat_in_t b;
        configure(16'd4, gbhe_pkg::MODE_EOI, gbhe_pkg::MAX_RX_RST, 16'd0);
        send_beat(source_beat(8'hFF, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1));  // no listener
        send_beat(source_beat(8'hA5, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0));  // ATN low, EOI held
        send_beat(listener(1'b0, 1'b0));           // settle
        b = listener(1'b0, 1'b0);
        b.command = gbhe_pkg::CMD_SEND;            // busy: refused
        send_beat(b);
        send_beat(listener(1'b1, 1'b0));           // NRFD high: DAV pulled
        send_beat(listener(1'b1, 1'b0));           // settle
        send_beat(listener(1'b1, 1'b0));           // NDAC still low
        b = listener(1'b1, 1'b1);
        b.command = gbhe_pkg::CMD_RECV;            // byte done wins over refusal
        send_beat(b);
        send_beat(cmd_beat(gbhe_pkg::CMD_RECV));   // message open: refused
        // second byte skips the listener check and keeps ATN
        send_beat(source_beat(8'h5A, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1));
        respond_until_idle(listener(1'b1, 1'b1));
        // plain data message, last byte without EOI
        send_beat(source_beat(8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
        respond_until_idle(listener(1'b1, 1'b1));
    endtask

    // Zero limit trips on the first unanswered sample of every wait; a
    // longer limit runs its full count before giving up.
    task automatic test_timeouts();
        configure(16'd0, gbhe_pkg::MODE_EOI, gbhe_pkg::MAX_RX_RST, 16'd0);
        send_beat(cmd_beat(gbhe_pkg::CMD_RECV));
        send_beat(talker(1'b1, 1'b1, 8'h00));      // DAV wait
        send_beat(cmd_beat(gbhe_pkg::CMD_RECV));
        send_beat(talker(1'b0, 1'b1, 8'h33));
        send_beat(talker(1'b0, 1'b1, 8'h33));      // DAV release wait
        send_beat(source_beat(8'h96, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        respond_until_idle(listener(1'b0, 1'b0));  // NRFD wait
        send_beat(source_beat(8'h69, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0));
        send_beat(listener(1'b0, 1'b0));
        send_beat(listener(1'b1, 1'b0));
        respond_until_idle(listener(1'b1, 1'b0));  // NDAC wait

        configure(16'd40, gbhe_pkg::MODE_EOI, gbhe_pkg::MAX_RX_RST, 16'd0);
        send_beat(cmd_beat(gbhe_pkg::CMD_RECV));
        respond_until_idle(talker(1'b1, 1'b1, 8'h00));
    endtask

    // Long settle time, once each side of DAV.
    task automatic test_long_settle();
        configure(16'd2, gbhe_pkg::MODE_EOI, gbhe_pkg::MAX_RX_RST, 16'd20);
        send_beat(source_beat(8'hC3, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0));
        respond_until_idle(listener(1'b1, 1'b1));
    endtask

    // Four traffic phases, each with its own idling and register setting.
    task automatic test_random_traffic();
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin
                    send_idle_pct = 0;  stall_pct = 0;
                    configure(16'd8, gbhe_pkg::MODE_EOI, 7'd5, 16'd2);
                end
                1: begin
                    send_idle_pct = 80; stall_pct = 0;
                    configure(16'd3, gbhe_pkg::MODE_LF, 7'd127, 16'd0);
                end
                2: begin
                    send_idle_pct = 0;  stall_pct = 80;
                    configure(16'd20, gbhe_pkg::MODE_LENGTH, 7'd3, 16'd5);
                end
                default: begin
                    send_idle_pct = 24; stall_pct = 24;
                    configure(gbhe_pkg::TickW'($urandom_range(2, 12)), MODE_SPARE,
                              gbhe_pkg::CountW'($urandom_range(1, 4)), 16'd1);
                end
            endcase
            repeat (110) send_beat(random_beat());
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_defaults();
        test_receive_modes();
        test_send_path();
        test_timeouts();
        test_long_settle();
        test_random_traffic();

        s_valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);   // catch any stray result beat
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

>>> gpib_byte_handshake_engine.f
rtl/gbhe_pkg.sv
rtl/gbhe_fsm.sv
rtl/gpib_byte_handshake_engine.sv
bench/tb_gpib_byte_handshake_engine.sv
